// ----- hdl/qstm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qstm_pkg;

  localparam int unsigned QuatW  = 16;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned TransW = 32;
  localparam int unsigned MatW   = 32;
  localparam int unsigned PrdW   = 32;
  localparam int unsigned EntW   = 34;
  localparam int unsigned MulW   = EntW + ScaleW;
  localparam int unsigned DropBits = 18;

  typedef logic signed [PrdW-1:0] prd_t;
  typedef logic signed [EntW-1:0] entry_t;
  typedef logic signed [MulW-1:0] mul_t;
  typedef logic signed [MatW-1:0] mat_t;

  localparam entry_t OneQ30 = entry_t'(34'sd1073741824);

  typedef struct packed {
    logic mul_en;
    logic out_en;
  } stg_ctl_t;

  // sign-extend one Q2.30 product into the entry width
  function automatic entry_t ext_prd(input prd_t a);
    ext_prd = {{(EntW-PrdW){a[PrdW-1]}}, a};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/qstm_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qstm_scale (
  input  wire logic                                clk_i,
  input  wire qstm_pkg::stg_ctl_t                  ctl_i,
  input  wire qstm_pkg::entry_t                    ent_i,
  input  wire logic signed [qstm_pkg::ScaleW-1:0]  scale_i,
  output qstm_pkg::mat_t                           m_o
);
  import qstm_pkg::*;

  mul_t                  prod_d, prod_q;
  logic signed [MulW:0]  rnd;
  logic signed [MulW-DropBits:0] shr;
  mat_t                  m_d, m_q;

  assign prod_d = mul_t'(ent_i) * mul_t'(scale_i);

  always_comb begin
    // add half an output lsb, then floor
    rnd = {prod_q[MulW-1], prod_q} + {{(MulW-DropBits+1){1'b0}}, 1'b1, {(DropBits-1){1'b0}}};
    shr = rnd[MulW:DropBits];
    if (shr[MulW-DropBits] != shr[MatW-1]) begin
      m_d = shr[MulW-DropBits] ? {1'b1, {(MatW-1){1'b0}}} : {1'b0, {(MatW-1){1'b1}}};
    end else begin
      m_d = shr[MatW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctl_i.out_en) begin
      m_q <= m_d;
    end
  end

  assign m_o = m_q;

endmodule

`default_nettype wire

// ----- hdl/quat_scale_translate_to_matrix_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes the quaternion product, entry sum and scale product registers
// into the output register, where its result is shown.
// Throughput: one item per cycle while not stalled; four register stages (quaternion products,
// entry sums, scale multiply, round and saturate) each take a new item every cycle unless held.
// A stage holds its item while the stage after it is full and stalled.
// Reset clears the stage valid bits only; data registers are not reset.

module quat_scale_translate_to_matrix_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  output logic                                     stall_o,
  input  wire logic signed [qstm_pkg::QuatW-1:0]   quat_x_i,
  input  wire logic signed [qstm_pkg::QuatW-1:0]   quat_y_i,
  input  wire logic signed [qstm_pkg::QuatW-1:0]   quat_z_i,
  input  wire logic signed [qstm_pkg::QuatW-1:0]   quat_w_i,
  input  wire logic signed [qstm_pkg::ScaleW-1:0]  scale_x_i,
  input  wire logic signed [qstm_pkg::ScaleW-1:0]  scale_y_i,
  input  wire logic signed [qstm_pkg::ScaleW-1:0]  scale_z_i,
  input  wire logic signed [qstm_pkg::TransW-1:0]  trans_x_i,
  input  wire logic signed [qstm_pkg::TransW-1:0]  trans_y_i,
  input  wire logic signed [qstm_pkg::TransW-1:0]  trans_z_i,
  output logic                                     valid_o,
  input  wire logic                                stall_i,
  output logic signed [qstm_pkg::MatW-1:0]         m00_o,
  output logic signed [qstm_pkg::MatW-1:0]         m01_o,
  output logic signed [qstm_pkg::MatW-1:0]         m02_o,
  output logic signed [qstm_pkg::MatW-1:0]         m10_o,
  output logic signed [qstm_pkg::MatW-1:0]         m11_o,
  output logic signed [qstm_pkg::MatW-1:0]         m12_o,
  output logic signed [qstm_pkg::MatW-1:0]         m20_o,
  output logic signed [qstm_pkg::MatW-1:0]         m21_o,
  output logic signed [qstm_pkg::MatW-1:0]         m22_o,
  output logic signed [qstm_pkg::TransW-1:0]       m30_o,
  output logic signed [qstm_pkg::TransW-1:0]       m31_o,
  output logic signed [qstm_pkg::TransW-1:0]       m32_o
);
  import qstm_pkg::*;

  typedef logic signed [ScaleW-1:0] scl_t;
  typedef logic signed [TransW-1:0] trn_t;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  prd_t xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, xw_q, yw_q, zw_q;
  scl_t sc1_q [3];
  scl_t sc2_q [3];
  trn_t tr1_q [3];
  trn_t tr2_q [3];
  trn_t tr3_q [3];
  trn_t tr4_q [3];
  entry_t ent_d [9];
  entry_t ent_q [9];
  mat_t   m_w   [9];
  stg_ctl_t ctl;

  // a stage takes a new item when it is empty or its item moves on
  assign rdy4 = !v4_q || !stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: quaternion products, exact in Q2.30
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      xx_q <= prd_t'(quat_x_i) * prd_t'(quat_x_i);
      yy_q <= prd_t'(quat_y_i) * prd_t'(quat_y_i);
      zz_q <= prd_t'(quat_z_i) * prd_t'(quat_z_i);
      xy_q <= prd_t'(quat_x_i) * prd_t'(quat_y_i);
      xz_q <= prd_t'(quat_x_i) * prd_t'(quat_z_i);
      yz_q <= prd_t'(quat_y_i) * prd_t'(quat_z_i);
      xw_q <= prd_t'(quat_x_i) * prd_t'(quat_w_i);
      yw_q <= prd_t'(quat_y_i) * prd_t'(quat_w_i);
      zw_q <= prd_t'(quat_z_i) * prd_t'(quat_w_i);
      sc1_q[0] <= scale_x_i;
      sc1_q[1] <= scale_y_i;
      sc1_q[2] <= scale_z_i;
      tr1_q[0] <= trans_x_i;
      tr1_q[1] <= trans_y_i;
      tr1_q[2] <= trans_z_i;
    end
  end

  // stage 2: rotation entries in Q.30
  always_comb begin
    ent_d[0] = OneQ30 - ((ext_prd(yy_q) + ext_prd(zz_q)) <<< 1);
    ent_d[1] = (ext_prd(xy_q) + ext_prd(zw_q)) <<< 1;
    ent_d[2] = (ext_prd(xz_q) - ext_prd(yw_q)) <<< 1;
    ent_d[3] = (ext_prd(xy_q) - ext_prd(zw_q)) <<< 1;
    ent_d[4] = OneQ30 - ((ext_prd(xx_q) + ext_prd(zz_q)) <<< 1);
    ent_d[5] = (ext_prd(yz_q) + ext_prd(xw_q)) <<< 1;
    ent_d[6] = (ext_prd(xz_q) + ext_prd(yw_q)) <<< 1;
    ent_d[7] = (ext_prd(yz_q) - ext_prd(xw_q)) <<< 1;
    ent_d[8] = OneQ30 - ((ext_prd(xx_q) + ext_prd(yy_q)) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      ent_q <= ent_d;
      sc2_q <= sc1_q;
      tr2_q <= tr1_q;
    end
    if (rdy3) begin
      tr3_q <= tr2_q;
    end
    if (rdy4) begin
      tr4_q <= tr3_q;
    end
  end

  // stages 3 and 4: scale multiply, then round and saturate
  assign ctl.mul_en = rdy3;
  assign ctl.out_en = rdy4;

  for (genvar k = 0; k < 9; k++) begin : g_ent
    qstm_scale u_scale (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .ent_i   (ent_q[k]),
      .scale_i (sc2_q[k/3]),
      .m_o     (m_w[k])
    );
  end

  assign valid_o = v4_q;
  assign m00_o = m_w[0];
  assign m01_o = m_w[1];
  assign m02_o = m_w[2];
  assign m10_o = m_w[3];
  assign m11_o = m_w[4];
  assign m12_o = m_w[5];
  assign m20_o = m_w[6];
  assign m21_o = m_w[7];
  assign m22_o = m_w[8];
  assign m30_o = tr4_q[0];
  assign m31_o = tr4_q[1];
  assign m32_o = tr4_q[2];

`ifndef SYNTHESIS
  logic       in_acc, out_acc;
  logic [2:0] occ;
  assign in_acc  = valid_i && !stall_o;
  assign out_acc = valid_o && !stall_i;
  assign occ     = 3'($countones({v1_q, v2_q, v3_q, v4_q}));

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with an empty stage");

  a_occ_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !out_acc) |=> (occ == $past(occ) + 3'd1))
    else $error("accepted item not held in the pipeline");

  a_occ_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !in_acc) |=> (occ + 3'd1 == $past(occ)))
    else $error("delivered item not removed from the pipeline");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !v3_q) |=> !valid_o)
    else $error("result shown without an item behind it");
`endif

endmodule

`default_nettype wire

// ----- verif/local_matrix_checker.sv -----
`timescale 1ns / 1ps

module local_matrix_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [qstm_pkg::QuatW-1:0]   quat_x_i,
  input  logic signed [qstm_pkg::QuatW-1:0]   quat_y_i,
  input  logic signed [qstm_pkg::QuatW-1:0]   quat_z_i,
  input  logic signed [qstm_pkg::QuatW-1:0]   quat_w_i,
  input  logic signed [qstm_pkg::ScaleW-1:0]  scale_x_i,
  input  logic signed [qstm_pkg::ScaleW-1:0]  scale_y_i,
  input  logic signed [qstm_pkg::ScaleW-1:0]  scale_z_i,
  input  logic signed [qstm_pkg::TransW-1:0]  trans_x_i,
  input  logic signed [qstm_pkg::TransW-1:0]  trans_y_i,
  input  logic signed [qstm_pkg::TransW-1:0]  trans_z_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [qstm_pkg::MatW-1:0]    m00_i,
  input  logic signed [qstm_pkg::MatW-1:0]    m01_i,
  input  logic signed [qstm_pkg::MatW-1:0]    m02_i,
  input  logic signed [qstm_pkg::MatW-1:0]    m10_i,
  input  logic signed [qstm_pkg::MatW-1:0]    m11_i,
  input  logic signed [qstm_pkg::MatW-1:0]    m12_i,
  input  logic signed [qstm_pkg::MatW-1:0]    m20_i,
  input  logic signed [qstm_pkg::MatW-1:0]    m21_i,
  input  logic signed [qstm_pkg::MatW-1:0]    m22_i,
  input  logic signed [qstm_pkg::TransW-1:0]  m30_i,
  input  logic signed [qstm_pkg::TransW-1:0]  m31_i,
  input  logic signed [qstm_pkg::TransW-1:0]  m32_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  checked_o,
  output int                                  sat_count_o
);

  import qstm_pkg::*;

  // entry k: m00, m01, m02, m10, m11, m12, m20, m21, m22, m30, m31, m32
  typedef logic [11:0][MatW-1:0] node_mat_t;

  localparam longint RotOne = longint'(1) <<< 30;
  localparam longint MatMax = 64'sd2147483647;
  localparam longint MatMin = -64'sd2147483648;

  node_mat_t pending_mats[$];
  int        fail_cnt;
  int        shown_cnt;
  int        checked_cnt;
  int        sat_cnt;

  initial begin
    fail_cnt     = 0;
    shown_cnt    = 0;
    checked_cnt  = 0;
    sat_cnt      = 0;
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    sat_count_o  = 0;
  end

  // Q.30 entry times Q4.12 scale, round half up to Q8.24, saturate
  function automatic mat_t scale_rot_entry(input longint rot, input longint scl);
    longint prod;
    longint rnd;
    prod = rot * scl;
    rnd  = (prod + (longint'(1) <<< (DropBits - 1))) >>> DropBits;
    if (rnd > MatMax) rnd = MatMax;
    if (rnd < MatMin) rnd = MatMin;
    return mat_t'(rnd[MatW-1:0]);
  endfunction

  function automatic node_mat_t calc_local_matrix(
    input logic signed [QuatW-1:0]  qx, qy, qz, qw,
    input logic signed [ScaleW-1:0] sx_in, sy_in, sz_in,
    input logic signed [TransW-1:0] tx, ty, tz
  );
    longint    x, y, z, w, sx, sy, sz;
    longint    xx, yy, zz, xy, xz, yz, xw, yw, zw;
    node_mat_t mat;
    x  = qx;
    y  = qy;
    z  = qz;
    w  = qw;
    sx = sx_in;
    sy = sy_in;
    sz = sz_in;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    xy = x * y;
    xz = x * z;
    yz = y * z;
    xw = x * w;
    yw = y * w;
    zw = z * w;
    mat[0]  = scale_rot_entry(RotOne - 2 * (yy + zz), sx);
    mat[1]  = scale_rot_entry(2 * (xy + zw), sx);
    mat[2]  = scale_rot_entry(2 * (xz - yw), sx);
    mat[3]  = scale_rot_entry(2 * (xy - zw), sy);
    mat[4]  = scale_rot_entry(RotOne - 2 * (xx + zz), sy);
    mat[5]  = scale_rot_entry(2 * (yz + xw), sy);
    mat[6]  = scale_rot_entry(2 * (xz + yw), sz);
    mat[7]  = scale_rot_entry(2 * (yz - xw), sz);
    mat[8]  = scale_rot_entry(RotOne - 2 * (xx + yy), sz);
    mat[9]  = tx;
    mat[10] = ty;
    mat[11] = tz;
    return mat;
  endfunction

  task automatic check_field(input string name, input mat_t want, input mat_t got);
    if (got !== want) begin
      fail_cnt++;
      if (shown_cnt < 40) begin
        shown_cnt++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    node_mat_t got;
    node_mat_t want;
    if (rst_ni) begin
      // check the output side first: a result leaving now belongs to an older item
      if (out_valid_i && !out_stall_i) begin
        got = {m32_i, m31_i, m30_i, m22_i, m21_i, m20_i,
               m12_i, m11_i, m10_i, m02_i, m01_i, m00_i};
        if (pending_mats.size() == 0) begin
          fail_cnt++;
          if (shown_cnt < 40) begin
            shown_cnt++;
            $display("%0t: result with no item pending, expected none actual m00=%h",
                     $time, got[0]);
          end
        end else begin
          want = pending_mats.pop_front();
          check_field("m00", want[0], got[0]);
          check_field("m01", want[1], got[1]);
          check_field("m02", want[2], got[2]);
          check_field("m10", want[3], got[3]);
          check_field("m11", want[4], got[4]);
          check_field("m12", want[5], got[5]);
          check_field("m20", want[6], got[6]);
          check_field("m21", want[7], got[7]);
          check_field("m22", want[8], got[8]);
          check_field("m30", want[9], got[9]);
          check_field("m31", want[10], got[10]);
          check_field("m32", want[11], got[11]);
          checked_cnt++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = calc_local_matrix(quat_x_i, quat_y_i, quat_z_i, quat_w_i,
                                 scale_x_i, scale_y_i, scale_z_i,
                                 trans_x_i, trans_y_i, trans_z_i);
        for (int k = 0; k < 9; k++) begin
          if (want[k] == 32'h7FFF_FFFF || want[k] == 32'h8000_0000) sat_cnt++;
        end
        pending_mats.push_back(want);
      end
    end
    fail_count_o <= fail_cnt;
    pending_o    <= pending_mats.size();
    checked_o    <= checked_cnt;
    sat_count_o  <= sat_cnt;
  end

endmodule

// ----- verif/quat_scale_translate_to_matrix_unit_test.sv -----
`timescale 1ns / 1ps

module quat_scale_translate_to_matrix_unit_test;

  import qstm_pkg::*;

  typedef struct packed {
    logic signed [QuatW-1:0]  qx;
    logic signed [QuatW-1:0]  qy;
    logic signed [QuatW-1:0]  qz;
    logic signed [QuatW-1:0]  qw;
    logic signed [ScaleW-1:0] sx;
    logic signed [ScaleW-1:0] sy;
    logic signed [ScaleW-1:0] sz;
    logic signed [TransW-1:0] tx;
    logic signed [TransW-1:0] ty;
    logic signed [TransW-1:0] tz;
  } node_xform_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic calm    = 1'b0;

  node_xform_t node = '0;

  logic                     stall_o;
  logic                     valid_o;
  logic signed [MatW-1:0]   m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;
  logic signed [TransW-1:0] m30_o, m31_o, m32_o;

  int fail_count;
  int pending_cnt;
  int checked_cnt;
  int sat_cnt;
  int sent_cnt = 0;

  quat_scale_translate_to_matrix_unit u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_i),
    .stall_o   (stall_o),
    .quat_x_i  (node.qx),
    .quat_y_i  (node.qy),
    .quat_z_i  (node.qz),
    .quat_w_i  (node.qw),
    .scale_x_i (node.sx),
    .scale_y_i (node.sy),
    .scale_z_i (node.sz),
    .trans_x_i (node.tx),
    .trans_y_i (node.ty),
    .trans_z_i (node.tz),
    .valid_o   (valid_o),
    .stall_i   (stall_i),
    .m00_o     (m00_o),
    .m01_o     (m01_o),
    .m02_o     (m02_o),
    .m10_o     (m10_o),
    .m11_o     (m11_o),
    .m12_o     (m12_o),
    .m20_o     (m20_o),
    .m21_o     (m21_o),
    .m22_o     (m22_o),
    .m30_o     (m30_o),
    .m31_o     (m31_o),
    .m32_o     (m32_o)
  );

  local_matrix_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid_i),
    .in_stall_i   (stall_o),
    .quat_x_i     (node.qx),
    .quat_y_i     (node.qy),
    .quat_z_i     (node.qz),
    .quat_w_i     (node.qw),
    .scale_x_i    (node.sx),
    .scale_y_i    (node.sy),
    .scale_z_i    (node.sz),
    .trans_x_i    (node.tx),
    .trans_y_i    (node.ty),
    .trans_z_i    (node.tz),
    .out_valid_i  (valid_o),
    .out_stall_i  (stall_i),
    .m00_i        (m00_o),
    .m01_i        (m01_o),
    .m02_i        (m02_o),
    .m10_i        (m10_o),
    .m11_i        (m11_o),
    .m12_i        (m12_o),
    .m20_i        (m20_o),
    .m21_i        (m21_o),
    .m22_i        (m22_o),
    .m30_i        (m30_o),
    .m31_i        (m31_o),
    .m32_i        (m32_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_cnt),
    .checked_o    (checked_cnt),
    .sat_count_o  (sat_cnt)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else begin
      stall_i <= !calm && ($urandom_range(99) < 17);
    end
  end

  function automatic node_xform_t mk_node(input int qx, qy, qz, qw, sx, sy, sz,
                                          input int tx, ty, tz);
    node_xform_t n;
    n.qx = qx[QuatW-1:0];
    n.qy = qy[QuatW-1:0];
    n.qz = qz[QuatW-1:0];
    n.qw = qw[QuatW-1:0];
    n.sx = sx[ScaleW-1:0];
    n.sy = sy[ScaleW-1:0];
    n.sz = sz[ScaleW-1:0];
    n.tx = tx;
    n.ty = ty;
    n.tz = tz;
    return n;
  endfunction

  function automatic logic [15:0] corner16();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic node_xform_t rand_node();
    node_xform_t  n;
    logic [223:0] raw;
    int           mode;
    raw  = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    n    = raw[207:0];
    mode = $urandom_range(3);
    if (mode == 1) begin
      // near-unit rotation with moderate scale, mostly in range
      n.qx = 16'($signed($urandom_range(46340)) - 23170);
      n.qy = 16'($signed($urandom_range(46340)) - 23170);
      n.qz = 16'($signed($urandom_range(46340)) - 23170);
      n.qw = 16'($signed($urandom_range(46340)) - 23170);
      n.sx = 16'($signed($urandom_range(16384)) - 8192);
      n.sy = 16'($signed($urandom_range(16384)) - 8192);
      n.sz = 16'($signed($urandom_range(16384)) - 8192);
    end else if (mode == 2) begin
      n.qx = corner16();
      n.qy = corner16();
      n.qz = corner16();
      n.qw = corner16();
      n.sx = corner16();
      n.sy = corner16();
      n.sz = corner16();
    end
    return n;
  endfunction

  task automatic push_node(input node_xform_t n);
    while (!calm && ($urandom_range(99) < 17)) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    node    <= n;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  // hold off the sender until every item in flight has come out
  task automatic drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  initial begin
    int directed_cnt;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_node(mk_node(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_node(mk_node(0, 0, 0, 32767, 4096, 4096, 4096, 32'h0001_0000, 32'hFFFF_0000, 0));
    push_node(mk_node(0, 0, 0, -32768, 4096, 4096, 4096, 1, 2, 3));
    push_node(mk_node(-32768, 0, 0, 0, 4096, 4096, 4096, 0, 0, 0));
    push_node(mk_node(0, -32768, 0, 0, 4096, -4096, 4096, 0, 0, 0));
    push_node(mk_node(0, 0, -32768, 0, -4096, 4096, 4096, 0, 0, 0));
    // unnormalized and saturating
    push_node(mk_node(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0));
    push_node(mk_node(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0, 0));
    push_node(mk_node(32767, 32767, 32767, 32767, 32767, -32768, 1, 0, 0, 0));
    push_node(mk_node(16384, 16384, 16384, 16384, 4096, 4096, 4096, 0, 0, 0));
    push_node(mk_node(23170, 0, 0, 23170, 8192, -8192, 4096, 0, 0, 0));
    // rounding ties, both signs
    push_node(mk_node(256, 256, 0, 0, 1, -1, 3, 0, 0, 0));
    push_node(mk_node(0, 0, 256, 256, -1, 1, -3, 0, 0, 0));
    push_node(mk_node(0, 0, 0, 32767, 4096, 4096, 4096,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    push_node(mk_node(1000, -2000, 3000, 30000, 4096, 4096, 4096,
                      32'h5555_5555, 32'hAAAA_AAAA, 1));
    push_node(mk_node(32767, -32768, 32767, -32768, 0, 0, 0, 0, 0, 0));
    push_node(mk_node(0, 0, 0, 32767, -32768, -32768, -32768, 0, 0, 0));
    push_node(mk_node(0, 0, 0, 32767, 32767, 32767, 32767, 0, 0, 0));
    push_node(mk_node(32767, -32768, 32767, -32768, 32767, -32768, 32767, -1, 0, -1));
    push_node(mk_node(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    directed_cnt = sent_cnt;
    drain();

    for (int i = 0; i < 1600; i++) begin
      if (i == 700) calm <= 1'b1;
      if (i == 1000) calm <= 1'b0;
      if (i == 400) drain();
      push_node(rand_node());
    end
    drain();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d node transforms (%0d directed), %0d results checked,",
             sent_cnt, directed_cnt, checked_cnt);
    $display("  %0d scaled rotation entries landed on the Q8.24 limits", sat_cnt);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
